/* hdl/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Each macro expands to one labeled concurrent assertion, clocked on the rising
// edge and held off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_AT(lbl, clk, rst_n, !(cond))

`endif

/* hdl/dds_pkg.sv */
// ----------------------------------------------------------------------------
// dds_pkg
// Shared constants, types and the divide-by-ten helper of the decimal digit
// scalar multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

	localparam int MULT_WIDTH_DEF = 24;  // default width of the used scalar
	localparam int CFG_WIDTH      = 24;  // width of the scalar register
	localparam int DIGIT_W        = 4;
	localparam int COUNT_W        = 4;
	localparam int MID_DEPTH      = 4;   // queue between front and back
	localparam int OUT_DEPTH      = 2;   // result queue
	localparam int DIV_W          = 32;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// x / 10 == (x * ceil(2^35 / 10)) >> 35, exact for every 32-bit x
	localparam logic [DIV_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int               DIV10_SHIFT = 35;

	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               fin;
		logic [COUNT_W-1:0] added;
	} res_t;

	function automatic logic [DIV_W-1:0] div10(input logic [DIV_W-1:0] x);
		logic [2*DIV_W-1:0] prod;
		prod = x * DIV10_RECIP;
		div10 = {{DIV10_SHIFT - DIV_W{1'b0}}, prod[2*DIV_W-1:DIV10_SHIFT]};
	endfunction

endpackage

`default_nettype wire

/* hdl/dds_fifo.sv */
// ----------------------------------------------------------------------------
// dds_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* hdl/dds_front.sv */
// ----------------------------------------------------------------------------
// dds_front
// Input stage: clamp the digit, form digit times scalar, hand it to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_front #(
	parameter  int MULT_WIDTH = dds_pkg::MULT_WIDTH_DEF,
	localparam int EW = (MULT_WIDTH < dds_pkg::CFG_WIDTH) ? MULT_WIDTH : dds_pkg::CFG_WIDTH,
	localparam int SW = EW + dds_pkg::DIGIT_W
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [dds_pkg::DIGIT_W-1:0]        digit_in,
	input  wire logic                               last_digit,
	input  wire logic [EW-1:0]                      mult,
	output logic                                    mid_push,
	input  wire logic                               mid_full,
	output logic      [SW:0]                        mid_data
);

	logic                        valid_s1;
	logic [SW-1:0]               prod_s1;
	logic                        last_s1;
	logic [dds_pkg::DIGIT_W-1:0] digit_sat;
	logic                        take;

	// digits above nine count as nine
	assign digit_sat = (digit_in > dds_pkg::DIGIT_MAX) ? dds_pkg::DIGIT_MAX : digit_in;

	assign full     = valid_s1 && mid_full;
	assign take     = push && !full;
	assign mid_push = valid_s1;
	assign mid_data = {last_s1, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && mid_full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= SW'(mult) * SW'(digit_sat);
			last_s1 <= last_digit;
		end
	end

endmodule

`default_nettype wire

/* hdl/dds_back.sv */
// ----------------------------------------------------------------------------
// dds_back
// Carry stage: add the running carry, split off one decimal digit per cycle while
// the result queue has room, and flush the leftover carry after a number's last digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_back #(
	parameter  int MULT_WIDTH = dds_pkg::MULT_WIDTH_DEF,
	localparam int EW = (MULT_WIDTH < dds_pkg::CFG_WIDTH) ? MULT_WIDTH : dds_pkg::CFG_WIDTH,
	localparam int SW = EW + dds_pkg::DIGIT_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mid_empty,
	input  wire logic [SW:0]   mid_data,
	output logic               mid_pop,
	input  wire logic          out_full,
	output logic               out_push,
	output dds_pkg::res_t      out_data
);

	localparam int DW = dds_pkg::DIV_W;

	dds_pkg::back_state_t state_q;
	dds_pkg::back_state_t state_d;

	logic [EW-1:0]               carry_q;
	logic [EW-1:0]               fc_q;
	logic [dds_pkg::COUNT_W-1:0] cnt_q;

	logic [SW-1:0]               head_p;
	logic                        head_last;
	logic [SW-1:0]               sum;
	logic [DW-1:0]               div_in;
	logic [DW-1:0]               quo;
	logic [DW-1:0]               rem_full;
	logic                        quo_zero;

	assign head_p    = mid_data[SW-1:0];
	assign head_last = mid_data[SW];
	assign sum       = head_p + SW'(carry_q);

	// one divider, fed by the new sum or by the carry being flushed
	assign div_in   = (state_q == dds_pkg::ST_FLUSH) ? {{(DW - EW){1'b0}}, fc_q}
	                                                 : {{(DW - SW){1'b0}}, sum};
	assign quo      = dds_pkg::div10(div_in);
	assign rem_full = div_in - ((quo << 3) + (quo << 1));
	assign quo_zero = (quo == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dds_pkg::ST_RUN: begin
				if (!mid_empty && !out_full && head_last && !quo_zero) begin
					state_d = dds_pkg::ST_FLUSH;
				end
			end
			dds_pkg::ST_FLUSH: begin
				if (!out_full && quo_zero) begin
					state_d = dds_pkg::ST_RUN;
				end
			end
			default: state_d = dds_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		mid_pop        = 1'b0;
		out_push       = 1'b0;
		out_data.digit = rem_full[dds_pkg::DIGIT_W-1:0];
		out_data.fin   = 1'b0;
		out_data.added = '0;
		case (state_q)
			dds_pkg::ST_RUN: begin
				mid_pop      = !mid_empty && !out_full;
				out_push     = !mid_empty && !out_full;
				out_data.fin = head_last && quo_zero;
			end
			dds_pkg::ST_FLUSH: begin
				out_push     = !out_full;
				out_data.fin = quo_zero;
				if (quo_zero) begin
					out_data.added = cnt_q + 1'b1;
				end
			end
			default: begin
				mid_pop  = 1'b0;
				out_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dds_pkg::ST_RUN;
			carry_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_push) begin
				case (state_q)
					dds_pkg::ST_RUN: begin
						carry_q <= head_last ? '0 : quo[EW-1:0];
						cnt_q   <= '0;
					end
					dds_pkg::ST_FLUSH: begin
						cnt_q <= cnt_q + 1'b1;
					end
					default: cnt_q <= '0;
				endcase
			end
		end
	end

	// remaining carry during a flush
	always_ff @(posedge clk) begin
		if (out_push) begin
			fc_q <= quo[EW-1:0];
		end
	end

endmodule

`default_nettype wire

/* hdl/decimal_digit_scalar_multiply.sv */
// ----------------------------------------------------------------------------
// decimal_digit_scalar_multiply
// Multiplies a decimal number, streamed least significant digit first, by a
// configured scalar and streams out the product digits with carry flush.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------
//   input     push / full          digit_in[3:0], last_digit
//   config    cfg_valid/cfg_ready  cfg_data[23:0] (scalar)
//   result    empty / pop          digit_out[3:0], final_flag, added_digits
//
// One digit enters per cycle while full is low; a result passes the input
// register, the middle queue and the result queue in that order before it
// shows on the ports, and can be popped once shown.
// A last digit that leaves a nonzero carry makes the back end append the
// carry's digits (at most eight) one at a time through its single divide-by-ten
// unit. The front keeps taking digits until the 4-entry queue fills.
// Reset clears the queues, the carry and the scalar; cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_scalar_multiply #(
	parameter int MULT_WIDTH = dds_pkg::MULT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// digit input
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [dds_pkg::DIGIT_W-1:0]   digit_in,
	input  wire logic                          last_digit,
	// scalar write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dds_pkg::CFG_WIDTH-1:0] cfg_data,
	// product digits
	output logic                               empty,
	input  wire logic                          pop,
	output logic      [dds_pkg::DIGIT_W-1:0]   digit_out,
	output logic                               final_flag,
	output logic      [dds_pkg::COUNT_W-1:0]   added_digits
);

	// only the low bits of the scalar take part when MULT_WIDTH is narrow
	localparam int EW = (MULT_WIDTH < dds_pkg::CFG_WIDTH) ? MULT_WIDTH : dds_pkg::CFG_WIDTH;
	localparam int SW = EW + dds_pkg::DIGIT_W;
	localparam int RW = $bits(dds_pkg::res_t);

	logic [dds_pkg::CFG_WIDTH-1:0] mult_q;

	logic          mid_push;
	logic          mid_full;
	logic [SW:0]   mid_wdata;
	logic          mid_pop;
	logic [SW:0]   mid_rdata;
	logic          mid_empty;

	logic          out_push;
	logic          out_full;
	dds_pkg::res_t out_wdata;
	dds_pkg::res_t out_rdata;

	// the scalar register takes every write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mult_q <= cfg_data;
		end
	end

	// front: clamp digit, multiply by the scalar, register the product
	dds_front #(
		.MULT_WIDTH (MULT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.digit_in   (digit_in),
		.last_digit (last_digit),
		.mult       (mult_q[EW-1:0]),
		.mid_push   (mid_push),
		.mid_full   (mid_full),
		.mid_data   (mid_wdata)
	);

	// decouple the front from the back while a carry is flushed
	dds_fifo #(
		.WIDTH (SW + 1),
		.DEPTH (dds_pkg::MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	// back: add carry, emit one product digit per cycle while the result queue has room
	dds_back #(
		.MULT_WIDTH (MULT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_wdata)
	);

	// hold finished items until the consumer pops them
	dds_fifo #(
		.WIDTH (RW),
		.DEPTH (dds_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign digit_out    = out_rdata.digit;
	assign final_flag   = out_rdata.fin;
	assign added_digits = out_rdata.added;

endmodule

`default_nettype wire

/* hdl/dds_checker.sv */
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks of the decimal digit scalar multiplier, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dds_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [3:0]  digit_out,
	input wire logic        final_flag,
	input wire logic [3:0]  added_digits
);

	// every shown item is a decimal digit
	`ASSERT_NEVER(a_digit_range, clk, arst_n, !empty && (digit_out > 4'd9))

	// flush count only on the final item, and never past eight
	`ASSERT_NEVER(a_added_only_final, clk, arst_n,
		!empty && (added_digits != 4'd0) && !final_flag)
	`ASSERT_NEVER(a_added_max, clk, arst_n, !empty && (added_digits > 4'd8))

	// a waiting item holds until popped
	`ASSERT_AT(a_result_hold, clk, arst_n,
		(!empty && !pop) |=> (!empty && $stable(digit_out) && $stable(final_flag) &&
		$stable(added_digits)))

endmodule

bind decimal_digit_scalar_multiply dds_checker u_dds_checker (.*);

`default_nettype wire
